/* src/xcrc_pkg.sv */
// Package for the XMODEM-CRC receiver: types, codes, reset values and the CRC step.
// No dependencies; the receiver core and the checker import it.
package xcrc_pkg;

    // Frame geometry default
    localparam int unsigned PAYLOAD_BYTES_DEF = 128;

    // Configuration register widths and reset values
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [15:0] TIMEOUT_RST = 16'd5000;
    localparam logic [15:0] POLL_RST    = 16'd3000;
    localparam logic [7:0]  RETRY_RST   = 8'd10;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PACKET_TIMEOUT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLL_INTERVAL  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_LIMIT    = 2'd2;

    // Command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Line characters
    localparam logic [7:0] CH_SOH  = 8'h01;
    localparam logic [7:0] CH_EOT  = 8'h04;
    localparam logic [7:0] CH_ACK  = 8'h06;
    localparam logic [7:0] CH_NAK  = 8'h15;
    localparam logic [7:0] CH_CAN  = 8'h18;
    localparam logic [7:0] CH_POLL = 8'h43;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_POLL = 3'd1,
        PH_WAIT = 3'd2,
        PH_RECV = 3'd3,
        PH_DONE = 3'd4,
        PH_ERR  = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_CANCEL   = 3'd1,
        ST_TIMEOUT  = 3'd2,
        ST_SEQ      = 3'd3,
        ST_CRC      = 3'd4,
        ST_COMPLETE = 3'd5
    } t_status;

    // Events decoded from one accepted transaction
    typedef struct packed {
        logic start;
        logic poll;
        logic poll_expire;
        logic wait_timeout;
        logic open;
        logic cancel;
        logic eot;
        logic frame_end;
        logic good;
    } t_evt;

    // CRC-16/XMODEM, one byte, MSB first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* src/xcrc_if.sv */
// Handshake channels of the XMODEM-CRC receiver: input items and result items.
// No dependencies.
interface xcrc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] rx_byte;

    modport source (output valid, cmd, rx_byte, input ready);
    modport sink (input valid, cmd, rx_byte, output ready);
endinterface

interface xcrc_out_if;
    logic        valid;
    logic        ready;
    logic        send_valid;
    logic [7:0]  send_byte;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [6:0]  data_index;
    logic        packet_done;
    logic        packet_good;
    logic [7:0]  packet_number;
    logic [2:0]  status;
    logic [2:0]  phase;
    logic [15:0] accepted_count;

    modport source (output valid, send_valid, send_byte, data_valid, data_byte, data_index,
                    packet_done, packet_good, packet_number, status, phase,
                    accepted_count, input ready);
    modport sink (input valid, send_valid, send_byte, data_valid, data_byte, data_index,
                  packet_done, packet_good, packet_number, status, phase,
                  accepted_count, output ready);
endinterface

/* src/xmodem_crc_packet_receiver_core.sv */
// An accepted input transaction's result is registered and shows on o_out in the cycle after it is accepted.
// Throughput: one transaction per cycle unless o_out stalls; the whole per-item step (state decode, CRC byte
// update, verdict compares) sits between the input handshake and the result register.
// i_in.ready is high whenever the result register is empty or being taken this cycle.
// Reset (i_rst_n low, synchronous): phase idle, counters zero, expected sequence one,
// configuration back to 5000 / 3000 / 10 ticks and polls, result register empty.
module xmodem_crc_packet_receiver_core #(
    parameter int unsigned PAYLOAD_BYTES = xcrc_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [xcrc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [xcrc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    xcrc_in_if.sink                            i_in,
    xcrc_out_if.source                         o_out
);
    import xcrc_pkg::*;

    // Frame byte position: SOH is 0, sequence 1, complement 2, payload from 3,
    // CRC high at PAYLOAD_BYTES+3, CRC low at PAYLOAD_BYTES+4.
    localparam int unsigned POS_W = $clog2(PAYLOAD_BYTES + 5);
    localparam logic [POS_W-1:0] POS_SEQ     = POS_W'(1);
    localparam logic [POS_W-1:0] POS_COMP    = POS_W'(2);
    localparam logic [POS_W-1:0] POS_DATA    = POS_W'(3);
    localparam logic [POS_W-1:0] POS_CRC_HI  = POS_W'(PAYLOAD_BYTES + 3);
    localparam logic [POS_W-1:0] POS_LAST    = POS_W'(PAYLOAD_BYTES + 4);

    // Configuration
    logic [15:0] r_timeout;
    logic [15:0] r_poll_interval;
    logic [7:0]  r_retry_limit;

    // Transfer state
    t_phase          r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]      r_exp_seq, n_exp_seq;
    logic [7:0]      r_seq, n_seq;
    logic [7:0]      r_comp, n_comp;
    logic [15:0]     r_crc, n_crc;
    logic [7:0]      r_crc_hi, n_crc_hi;
    logic [15:0]     r_elapsed, n_elapsed;
    logic [7:0]      r_retries, n_retries;
    logic [15:0]     r_frames, n_frames;

    // Result register
    logic        r_ovalid;
    logic        r_send_valid, n_send_valid;
    logic [7:0]  r_send_byte, n_send_byte;
    logic        r_data_valid, n_data_valid;
    logic [7:0]  r_data_byte, n_data_byte;
    logic [6:0]  r_data_index, n_data_index;
    logic        r_done, n_done;
    logic        r_good, n_good;
    logic [7:0]  r_pkt_num, n_pkt_num;
    t_status     r_status, n_status;

    logic        accept;
    logic        is_byte;
    logic        is_tick;
    logic        in_frame;
    logic        payload;
    logic        seq_bad;
    logic        crc_bad;
    logic [15:0] tick_sat;
    logic [7:0]  retries_inc;
    logic [POS_W-1:0] pos_off;
    t_evt        evt;

    assign i_in.ready = !r_ovalid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // Event decode: everything below hangs off these flags
    always_comb begin
        tick_sat    = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;
        is_byte     = accept && (i_in.cmd == CMD_BYTE);
        is_tick     = accept && (i_in.cmd == CMD_TICK);
        evt.start   = accept && (i_in.cmd == CMD_START);
        // start clears the retry count before its own poll counts
        retries_inc = evt.start ? 8'd1 :
                      ((r_retries == 8'hFF) ? r_retries : r_retries + 8'd1);
        evt.poll    = evt.start ||
                      (is_tick && (r_phase == PH_POLL) && (tick_sat >= r_poll_interval));
        evt.poll_expire  = evt.poll && (retries_inc >= r_retry_limit);
        evt.wait_timeout = is_tick && ((r_phase == PH_WAIT) || (r_phase == PH_RECV)) &&
                           (tick_sat >= r_timeout);
        evt.open    = is_byte && ((r_phase == PH_POLL) || (r_phase == PH_WAIT)) &&
                      (i_in.rx_byte == CH_SOH);
        evt.cancel  = is_byte && ((r_phase == PH_POLL) || (r_phase == PH_WAIT)) &&
                      (i_in.rx_byte == CH_CAN);
        evt.eot     = is_byte && (r_phase == PH_WAIT) && (i_in.rx_byte == CH_EOT);
        in_frame    = is_byte && (r_phase == PH_RECV);
        payload     = in_frame && (r_pos >= POS_DATA) && (r_pos < POS_CRC_HI);
        evt.frame_end = in_frame && (r_pos == POS_LAST);
        seq_bad     = ((r_seq ^ r_comp) != 8'hFF) || (r_seq != r_exp_seq);
        crc_bad     = {r_crc_hi, i_in.rx_byte} != r_crc;
        evt.good    = evt.frame_end && !seq_bad && !crc_bad;
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (evt.start) begin
            n_phase = evt.poll_expire ? PH_ERR : PH_POLL;
        end else if (evt.poll_expire || evt.wait_timeout || evt.cancel) begin
            n_phase = PH_ERR;
        end else if (evt.open) begin
            n_phase = PH_RECV;
        end else if (evt.eot) begin
            n_phase = PH_DONE;
        end else if (evt.frame_end) begin
            n_phase = PH_WAIT;
        end
    end

    // Datapath and result fields
    always_comb begin
        n_pos     = r_pos;
        n_exp_seq = r_exp_seq;
        n_seq     = r_seq;
        n_comp    = r_comp;
        n_crc     = r_crc;
        n_crc_hi  = r_crc_hi;
        n_elapsed = r_elapsed;
        n_retries = r_retries;
        n_frames  = r_frames;
        pos_off   = r_pos - POS_DATA;

        if (evt.start) begin
            n_pos     = '0;
            n_exp_seq = 8'd1;
            n_seq     = '0;
            n_comp    = '0;
            n_crc     = '0;
            n_crc_hi  = '0;
            n_frames  = '0;
        end

        // tick counting while polling, waiting or receiving
        if (is_tick && ((r_phase == PH_POLL) || (r_phase == PH_WAIT) ||
                        (r_phase == PH_RECV))) begin
            n_elapsed = tick_sat;
        end
        if (evt.poll) begin
            n_elapsed = '0;
            n_retries = retries_inc;
        end

        if (evt.open) begin
            n_pos     = POS_SEQ;
            n_crc     = '0;
            n_elapsed = '0;
        end

        if (in_frame) begin
            n_pos = r_pos + POS_W'(1);
            if (r_pos == POS_SEQ) begin
                n_seq = i_in.rx_byte;
            end
            if (r_pos == POS_COMP) begin
                n_comp = i_in.rx_byte;
            end
            if (payload) begin
                n_crc = crc_feed(r_crc, i_in.rx_byte);
            end
            if (r_pos == POS_CRC_HI) begin
                n_crc_hi = i_in.rx_byte;
            end
        end

        if (evt.frame_end) begin
            n_pos     = '0;
            n_elapsed = '0;
        end
        if (evt.good) begin
            n_exp_seq = r_exp_seq + 8'd1;
            n_frames  = r_frames + 16'd1;
        end

        // result fields
        n_send_valid = evt.poll || evt.eot || evt.frame_end;
        if (evt.poll) begin
            n_send_byte = CH_POLL;
        end else if (evt.eot || evt.good) begin
            n_send_byte = CH_ACK;
        end else if (evt.frame_end) begin
            n_send_byte = CH_NAK;
        end else begin
            n_send_byte = '0;
        end
        n_data_valid = payload;
        n_data_byte  = payload ? i_in.rx_byte : '0;
        n_data_index = payload ? pos_off[6:0] : '0;
        n_done       = evt.frame_end;
        n_good       = evt.good;
        n_pkt_num    = evt.frame_end ? r_seq : '0;

        if (evt.poll_expire || evt.wait_timeout) begin
            n_status = ST_TIMEOUT;
        end else if (evt.cancel) begin
            n_status = ST_CANCEL;
        end else if (evt.frame_end && seq_bad) begin
            n_status = ST_SEQ;
        end else if (evt.frame_end && crc_bad) begin
            n_status = ST_CRC;
        end else if (evt.eot) begin
            n_status = ST_COMPLETE;
        end else begin
            n_status = ST_NONE;
        end
    end

    // Configuration writes; an index past the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout       <= TIMEOUT_RST;
            r_poll_interval <= POLL_RST;
            r_retry_limit   <= RETRY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PACKET_TIMEOUT: r_timeout       <= i_cfg_data;
                CFG_POLL_INTERVAL:  r_poll_interval <= i_cfg_data;
                CFG_RETRY_LIMIT:    r_retry_limit   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Transfer state: advance only on an accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_pos     <= '0;
            r_exp_seq <= 8'd1;
            r_seq     <= '0;
            r_comp    <= '0;
            r_crc     <= '0;
            r_crc_hi  <= '0;
            r_elapsed <= '0;
            r_retries <= '0;
            r_frames  <= '0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_exp_seq <= n_exp_seq;
            r_seq     <= n_seq;
            r_comp    <= n_comp;
            r_crc     <= n_crc;
            r_crc_hi  <= n_crc_hi;
            r_elapsed <= n_elapsed;
            r_retries <= n_retries;
            r_frames  <= n_frames;
        end
    end

    // Result register: load on accept, hold while stalled, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (accept) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_send_valid <= n_send_valid;
            r_send_byte  <= n_send_byte;
            r_data_valid <= n_data_valid;
            r_data_byte  <= n_data_byte;
            r_data_index <= n_data_index;
            r_done       <= n_done;
            r_good       <= n_good;
            r_pkt_num    <= n_pkt_num;
            r_status     <= n_status;
        end
    end

    // Phase and count track the state registers, which only move on accept
    assign o_out.valid          = r_ovalid;
    assign o_out.send_valid     = r_send_valid;
    assign o_out.send_byte      = r_send_byte;
    assign o_out.data_valid     = r_data_valid;
    assign o_out.data_byte      = r_data_byte;
    assign o_out.data_index     = r_data_index;
    assign o_out.packet_done    = r_done;
    assign o_out.packet_good    = r_good;
    assign o_out.packet_number  = r_pkt_num;
    assign o_out.status         = r_status;
    assign o_out.phase          = r_phase;
    assign o_out.accepted_count = r_frames;

endmodule

/* src/xcrc_checker.sv */
// Port-level checks on the XMODEM-CRC receiver result channel, bound to the top level.
// Depends on xcrc_pkg and xmodem_crc_packet_receiver_core.
module xcrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_send_valid,
    input logic [7:0]  i_send_byte,
    input logic        i_data_valid,
    input logic        i_packet_done,
    input logic        i_packet_good,
    input logic [2:0]  i_status,
    input logic [2:0]  i_phase,
    input logic [15:0] i_accepted_count
);
    import xcrc_pkg::*;

    // a finished frame always answers with ACK or NAK matching its verdict
    a_verdict_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_packet_done |->
            i_send_valid && (i_packet_good ? (i_send_byte == CH_ACK) : (i_send_byte == CH_NAK)))
        else $error("frame verdict without matching reply");

    // a good frame reports no error and returns to waiting
    a_good_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_packet_good |-> i_packet_done && (i_status == ST_NONE) &&
            (i_phase == PH_WAIT))
        else $error("good frame with error status or wrong phase");

    // a payload byte only comes mid-frame and never with a reply
    a_payload_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_data_valid |-> (i_phase == PH_RECV) && !i_send_valid && !i_packet_done)
        else $error("payload byte outside a frame");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_send_byte) && $stable(i_status) &&
            $stable(i_accepted_count))
        else $error("stalled result changed");

endmodule

bind xmodem_crc_packet_receiver_core xcrc_checker u_xcrc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_out.valid),
    .i_ready          (o_out.ready),
    .i_send_valid     (o_out.send_valid),
    .i_send_byte      (o_out.send_byte),
    .i_data_valid     (o_out.data_valid),
    .i_packet_done    (o_out.packet_done),
    .i_packet_good    (o_out.packet_good),
    .i_status         (o_out.status),
    .i_phase          (o_out.phase),
    .i_accepted_count (o_out.accepted_count)
);
